### rtl/trlq_pkg.sv
// ----------------------------------------------------------------------------
// trlq_pkg
// Shared constants, codes and types for the three-level ready queue.
// ----------------------------------------------------------------------------
package trlq_pkg;

  localparam int CLASS_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int NUM_CLASSES = 3;
  localparam int FILL_W      = $clog2(CLASS_DEPTH + 1);
  localparam int TOTAL_W     = FILL_W + 2;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [FILL_W-1:0]  fill_t;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_ERASE = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CLS_RED    = 2'd0,
    CLS_ORANGE = 2'd1,
    CLS_GREEN  = 2'd2,
    CLS_NONE   = 2'd3
  } class_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic erase;
    logic tail;
    logic occupied;
  } cell_cmd_t;

endpackage

### rtl/trlq_cell.sv
// ----------------------------------------------------------------------------
// trlq_cell
// One queue slot: holds an id, compares it to the key and takes the id of its
// neighbor when the entry at or ahead of it is removed.
// ----------------------------------------------------------------------------
module trlq_cell import trlq_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  id_t       key_i,
  input  id_t       next_id_i,
  input  logic      hit_i,
  output logic      hit_o,
  output id_t       id_o
);

  id_t id_q, id_d;

  assign hit_o = hit_i | (cmd_i.occupied & (id_q == key_i));
  assign id_o  = id_q;

  always_comb begin
    id_d = id_q;
    if (cmd_i.push && cmd_i.tail) begin
      id_d = key_i;
    end else if (cmd_i.pop || (cmd_i.erase && hit_o)) begin
      id_d = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

### rtl/trlq_class.sv
// ----------------------------------------------------------------------------
// trlq_class
// One priority class: a row of slot cells with the head at cell 0 and a fill
// counter. Push writes the tail cell; pop and erase shift the row up.
// ----------------------------------------------------------------------------
module trlq_class import trlq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  logic  pop_i,
  input  logic  erase_i,
  input  id_t   key_i,
  output fill_t fill_o,
  output logic  full_o,
  output logic  found_o,
  output id_t   head_id_o
);

  fill_t fill_q, fill_d;
  id_t   cell_id [CLASS_DEPTH];
  logic  hit     [CLASS_DEPTH+1];

  assign hit[0] = 1'b0;

  for (genvar k = 0; k < CLASS_DEPTH; k++) begin : g_cell
    cell_cmd_t cmd;
    id_t       next_id;

    assign cmd.push     = push_i;
    assign cmd.pop      = pop_i;
    assign cmd.erase    = erase_i;
    assign cmd.tail     = (FILL_W'(k) == fill_q);
    assign cmd.occupied = (FILL_W'(k) < fill_q);

    if (k < CLASS_DEPTH - 1) begin : g_mid
      assign next_id = cell_id[k+1];
    end else begin : g_last
      assign next_id = cell_id[k];
    end

    trlq_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .key_i     (key_i),
      .next_id_i (next_id),
      .hit_i     (hit[k]),
      .hit_o     (hit[k+1]),
      .id_o      (cell_id[k])
    );
  end

  assign found_o   = hit[CLASS_DEPTH];
  assign full_o    = (fill_q == FILL_W'(CLASS_DEPTH));
  assign fill_o    = fill_q;
  assign head_id_o = cell_id[0];

  always_comb begin
    fill_d = fill_q;
    if (push_i) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop_i || (erase_i && found_o)) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

### rtl/three_level_ready_queue_core.sv
// ----------------------------------------------------------------------------
// three_level_ready_queue_core
// Strict-priority ready queue of thread ids in three classes.
// ----------------------------------------------------------------------------
// Holds up to 16 thread ids per class in red, orange and green FIFOs and
// serves red before orange before green. Each item pushes an id, pops the
// top head, or erases the first matching id from its class. One item is
// taken per cycle whenever the result register is empty or being emptied;
// every slot cell compares and shifts in parallel, so an operation completes
// in the cycle it is accepted and its result is shown from the next cycle
// until taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module three_level_ready_queue_core import trlq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] thread_id_i,
  input  logic [1:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       head_valid_o,
  output logic [7:0] head_id_o,
  output logic [1:0] head_class_o,
  output logic [5:0] total_count_o,
  output logic [1:0] status_o
);

  op_e                op;
  id_t                key;
  logic               in_fire;
  logic               cls_valid;
  logic               push_en  [NUM_CLASSES];
  logic               pop_en   [NUM_CLASSES];
  logic               erase_en [NUM_CLASSES];
  fill_t              fill     [NUM_CLASSES];
  logic               full     [NUM_CLASSES];
  logic               found    [NUM_CLASSES];
  id_t                head_id  [NUM_CLASSES];
  class_e             top_cls;
  status_e            status_d, status_q;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] total;

  assign op        = op_e'(op_i);
  assign key       = id_t'(thread_id_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire   = in_valid_i && in_ready_o;
  assign cls_valid = (priority_req_i != CLS_NONE);

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    trlq_class u_class (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .push_i    (push_en[c]),
      .pop_i     (pop_en[c]),
      .erase_i   (erase_en[c]),
      .key_i     (key),
      .fill_o    (fill[c]),
      .full_o    (full[c]),
      .found_o   (found[c]),
      .head_id_o (head_id[c])
    );
  end

  always_comb begin
    if (fill[CLS_RED] != '0) begin
      top_cls = CLS_RED;
    end else if (fill[CLS_ORANGE] != '0) begin
      top_cls = CLS_ORANGE;
    end else if (fill[CLS_GREEN] != '0) begin
      top_cls = CLS_GREEN;
    end else begin
      top_cls = CLS_NONE;
    end
  end

  always_comb begin
    status_d = ST_OK;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      push_en[c]  = 1'b0;
      pop_en[c]   = 1'b0;
      erase_en[c] = 1'b0;
    end
    case (op)
      OP_PUSH: begin
        if (cls_valid && !full[priority_req_i]) begin
          push_en[priority_req_i] = in_fire;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_POP: begin
        if (top_cls == CLS_NONE) begin
          status_d = ST_EMPTY;
        end else begin
          pop_en[top_cls] = in_fire;
        end
      end
      OP_ERASE: begin
        if (cls_valid && found[priority_req_i]) begin
          erase_en[priority_req_i] = in_fire;
        end else begin
          status_d = ST_MISSING;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
    end
  end

  assign total = TOTAL_W'(fill[CLS_RED]) + TOTAL_W'(fill[CLS_ORANGE])
               + TOTAL_W'(fill[CLS_GREEN]);

  assign out_valid_o   = out_valid_q;
  assign head_valid_o  = (top_cls != CLS_NONE);
  assign head_id_o     = head_valid_o ? 8'(head_id[top_cls]) : 8'd0;
  assign head_class_o  = head_valid_o ? top_cls : CLS_RED;
  assign total_count_o = total[5:0];
  assign status_o      = status_q;

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && op == OP_PUSH && status_d == ST_OK |=> total == $past(total) + TOTAL_W'(1))
    else $error("accepted push did not add one entry");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && op == OP_POP && status_d == ST_OK |=> total == $past(total) - TOTAL_W'(1))
    else $error("accepted pop did not remove one entry");

  a_miss_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && status_d != ST_OK |=> total == $past(total))
    else $error("failed operation changed the queue");

  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_o == (total != '0))
    else $error("head valid disagrees with total count");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-level ready queue core.
// ----------------------------------------------------------------------------
// Sends push, pop and erase items through the valid/ready input. A queue model
// of the three classes predicts every result, and each result taken from the
// output is compared with the oldest prediction. Both sides idle at random,
// except in one stretch of back-to-back traffic. The stimulus runs from a short
// directed set of corner cases through noise, fill and drain sequences and
// erase-heavy churn.
// ----------------------------------------------------------------------------
module testbench;
  import trlq_pkg::*;

  localparam int IDLE_PCT     = 29;
  localparam int STALL_LIMIT  = 1000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic       head_valid;
    logic [7:0] head_id;
    logic [1:0] head_class;
    logic [5:0] total_count;
    logic [1:0] status;
  } queue_view_t;

  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [1:0] op_i           = OP_NOP;
  logic [7:0] thread_id_i    = '0;
  logic [1:0] priority_req_i = CLS_RED;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic       head_valid_o;
  logic [7:0] head_id_o;
  logic [1:0] head_class_o;
  logic [5:0] total_count_o;
  logic [1:0] status_o;

  id_t         class_lists[NUM_CLASSES][$];
  queue_view_t expected_views[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  bit          steady_flow    = 1'b0;

  three_level_ready_queue_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .thread_id_i    (thread_id_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .head_valid_o   (head_valid_o),
    .head_id_o      (head_id_o),
    .head_class_o   (head_class_o),
    .total_count_o  (total_count_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic queue_view_t apply_queue_op(op_e op, id_t id, logic [1:0] cls);
    queue_view_t view;
    status_e     status;
    int          top;
    int          total;
    status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (cls == CLS_NONE || class_lists[cls].size() >= CLASS_DEPTH) begin
          status = ST_FULL;
        end else begin
          class_lists[cls].insert(class_lists[cls].size(), id);
        end
      end
      OP_POP: begin
        status = ST_EMPTY;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (status == ST_EMPTY && class_lists[c].size() != 0) begin
            class_lists[c].delete(0);
            status = ST_OK;
          end
        end
      end
      OP_ERASE: begin
        status = ST_MISSING;
        if (cls != CLS_NONE) begin
          for (int k = 0; k < class_lists[cls].size(); k++) begin
            if (status == ST_MISSING && class_lists[cls][k] == id) begin
              class_lists[cls].delete(k);
              status = ST_OK;
            end
          end
        end
      end
      default: ;
    endcase
    top   = NUM_CLASSES;
    total = 0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      total += class_lists[c].size();
      if (class_lists[c].size() != 0) top = c;
    end
    view.status      = status;
    view.total_count = 6'(total);
    if (top < NUM_CLASSES) begin
      view.head_valid = 1'b1;
      view.head_id    = class_lists[top][0];
      view.head_class = 2'(top);
    end else begin
      view.head_valid = 1'b0;
      view.head_id    = '0;
      view.head_class = CLS_RED;
    end
    return view;
  endfunction

  task automatic send_item(op_e op, id_t id, logic [1:0] cls);
    queue_view_t view;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    thread_id_i    <= id;
    priority_req_i <= cls;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    view = apply_queue_op(op, id, cls);
    expected_views.insert(expected_views.size(), view);
  endtask

  task automatic send_random(int push_pct, int pop_pct, int noise_pct);
    op_e        op;
    id_t        id;
    logic [1:0] cls;
    int         roll;
    roll = $urandom_range(99);
    if (roll < noise_pct) begin
      op  = op_e'($urandom_range(3));
      id  = id_t'($urandom);
      cls = 2'($urandom_range(3));
    end else begin
      cls  = ($urandom_range(19) == 0) ? CLS_NONE : 2'($urandom_range(2));
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        op = OP_PUSH;
        id = ($urandom_range(3) == 0) ? id_t'($urandom_range(7)) : id_t'($urandom);
      end else if (roll < push_pct + pop_pct) begin
        op = OP_POP;
        id = id_t'($urandom);
      end else begin
        op = OP_ERASE;
        if (cls != CLS_NONE && class_lists[cls].size() != 0 && $urandom_range(3) != 0) begin
          id = class_lists[cls][$urandom_range(class_lists[cls].size() - 1)];
        end else begin
          id = id_t'($urandom);
        end
      end
    end
    send_item(op, id, cls);
  endtask

  task automatic note_mismatch(string what, queue_view_t want, queue_view_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected valid=%0b id=%0d class=%0d total=%0d status=%0d",
               $realtime, what, want.head_valid, want.head_id, want.head_class,
               want.total_count, want.status);
      $display("%0t %s:   actual valid=%0b id=%0d class=%0d total=%0d status=%0d",
               $realtime, what, seen.head_valid, seen.head_id, seen.head_class,
               seen.total_count, seen.status);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(negedge clk_i) begin
    queue_view_t seen;
    queue_view_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (out_valid_o && out_ready_i) begin
        seen = '{head_valid_o, head_id_o, head_class_o, total_count_o, status_o};
        if (expected_views.size() == 0) begin
          note_mismatch("unexpected result", '0, seen);
        end else begin
          want = expected_views[0];
          expected_views.delete(0);
          if (seen.head_valid !== want.head_valid || seen.head_id !== want.head_id ||
              seen.head_class !== want.head_class ||
              seen.total_count !== want.total_count || seen.status !== want.status) begin
            note_mismatch("result mismatch", want, seen);
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_item(OP_POP, 8'h00, CLS_RED);
    send_item(OP_NOP, 8'hFF, CLS_NONE);
    send_item(OP_PUSH, 8'hFF, CLS_NONE);
    send_item(OP_ERASE, 8'hFF, CLS_NONE);
    for (int k = 0; k < CLASS_DEPTH; k++) begin
      if (k == 0) send_item(OP_PUSH, 8'h00, CLS_GREEN);
      else if (k == CLASS_DEPTH - 1) send_item(OP_PUSH, 8'hFF, CLS_GREEN);
      else if (k == 3 || k == 9) send_item(OP_PUSH, 8'h5A, CLS_GREEN);
      else send_item(OP_PUSH, id_t'($urandom), CLS_GREEN);
    end
    send_item(OP_PUSH, 8'hA5, CLS_GREEN);
    send_item(OP_ERASE, 8'h5A, CLS_GREEN);
    send_item(OP_ERASE, 8'h11, CLS_RED);
    send_item(OP_PUSH, 8'hFF, CLS_RED);
    send_item(OP_POP, 8'h00, CLS_NONE);
  endtask

  task automatic test_noise();
    repeat (80) send_random(0, 0, 100);
  endtask

  task automatic test_fill_and_drain();
    repeat (150) send_random(70, 10, 5);
    repeat (100) send_random(15, 60, 5);
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (120) send_random(45, 30, 5);
    steady_flow = 1'b0;
  endtask

  task automatic test_erase_churn();
    repeat (100) send_random(40, 25, 10);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_noise();
    test_fill_and_drain();
    test_back_to_back();
    test_erase_churn();
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/trlq_pkg.sv
rtl/trlq_cell.sv
rtl/trlq_class.sv
rtl/three_level_ready_queue_core.sv
dv/testbench.sv
